// ===== src/litw_pkg.sv =====
`default_nettype none

package litw_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 128;
  localparam int MIN_LEN     = 60;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int ADDR_W      = SLOT_W + 1;
  localparam int DEPTH       = 2 ** ADDR_W;

  // Field widths.
  localparam int LEN_W   = 16;
  localparam int SPAN_W  = 8;
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int TIME_W  = SEC_W + USEC_W;
  localparam int WIN_W   = 32;
  localparam int CMP_W   = ((SLOT_W > SPAN_W) ? SLOT_W : SPAN_W) + 1;

  // Age arithmetic widths: signed second and microsecond differences,
  // their scaled product and the final sum.
  localparam int SDIFF_W = SEC_W + 1;
  localparam int UDIFF_W = USEC_W + 1;
  localparam int PROD_W  = SDIFF_W + UDIFF_W;
  localparam int AGE_W   = PROD_W + 1;

  localparam logic signed [UDIFF_W-1:0] USEC_PER_SEC = UDIFF_W'(1000000);
  localparam logic [WIN_W-1:0]          WINDOW_RESET = WIN_W'(3000000);

  // Command codes of an input item.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_issue;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_query;
    logic last_idx;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  // Slot of a packet length: floored at zero, capped at the top slot.
  function automatic slot_t slot_of(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] diff;
    diff = len - LEN_W'(MIN_LEN);
    if (len <= LEN_W'(MIN_LEN)) begin
      return '0;
    end else if (diff > LEN_W'(TABLE_SLOTS - 1)) begin
      return SLOT_W'(TABLE_SLOTS - 1);
    end else begin
      return diff[SLOT_W-1:0];
    end
  endfunction

  // First slot of a query scan, floored at slot zero.
  function automatic slot_t scan_start(input slot_t slot, input logic [SPAN_W-1:0] span);
    logic [CMP_W-1:0] slot_ext;
    logic [CMP_W-1:0] span_ext;
    slot_ext = CMP_W'(slot);
    span_ext = CMP_W'(span);
    if (span_ext >= slot_ext) begin
      return '0;
    end else begin
      return SLOT_W'(slot_ext - span_ext);
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/litw_ctrl.sv =====
`default_nettype none

module litw_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  litw_pkg::dp_status_t   status,
  output litw_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Only the idle state takes a new item.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.is_query ? S_SCAN : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (status.last_idx) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/litw_dp.sv =====
`default_nettype none

module litw_dp (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  input  wire  [litw_pkg::WIN_W-1:0]          cfg_window_us,
  input  wire                                 in_cmd,
  input  wire  [litw_pkg::LEN_W-1:0]          in_pkt_len,
  input  wire  [litw_pkg::SPAN_W-1:0]         in_span_down,
  input  wire                                 in_direction,
  input  wire  [litw_pkg::SEC_W-1:0]          in_ts_sec,
  input  wire  [litw_pkg::USEC_W-1:0]         in_ts_usec,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                out_present,
  input  litw_pkg::ctrl_cmd_t                 cmd,
  output litw_pkg::dp_status_t                status
);

  // Item registers.
  logic                           dir_r;
  litw_pkg::slot_t                slot_r;
  litw_pkg::slot_t                idx_r;
  logic [litw_pkg::SEC_W-1:0]     now_sec_r;
  logic [litw_pkg::USEC_W-1:0]    now_usec_r;
  logic [litw_pkg::WIN_W-1:0]     window_r;
  litw_pkg::slot_t                in_slot;

  // Timestamp store for both directions, addressed by {direction, slot}.
  logic [litw_pkg::TIME_W-1:0]    mem [litw_pkg::DEPTH];
  logic [litw_pkg::DEPTH-1:0]     valid_r;
  logic [litw_pkg::ADDR_W-1:0]    wr_addr;
  logic [litw_pkg::ADDR_W-1:0]    rd_addr;

  // Compare pipeline.
  logic                                  v1_r;
  logic                                  v2_r;
  logic                                  v3_r;
  logic [litw_pkg::TIME_W-1:0]           rd_data_r;
  logic                                  rd_vld_r;
  logic [litw_pkg::TIME_W-1:0]           old_time;
  logic signed [litw_pkg::SDIFF_W-1:0]   sdiff_r;
  logic signed [litw_pkg::UDIFF_W-1:0]   udiff_r;
  logic signed [litw_pkg::PROD_W-1:0]    prod_r;
  logic signed [litw_pkg::PROD_W-1:0]    prod_nxt;
  logic signed [litw_pkg::UDIFF_W-1:0]   udiff3_r;
  logic signed [litw_pkg::AGE_W-1:0]     age;
  logic signed [litw_pkg::AGE_W-1:0]     window_ext;
  logic                                  hit_r;

  // Result register.
  logic                           out_valid_r;
  logic                           present_r;

  assign in_slot  = litw_pkg::slot_of(in_pkt_len);
  assign wr_addr  = {dir_r, slot_r};
  assign rd_addr  = {dir_r, idx_r};

  // Configuration register; the port is always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= litw_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      window_r <= cfg_window_us;
    end
  end

  // Capture an accepted item and set up the scan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_r      <= in_direction;
      slot_r     <= in_slot;
      idx_r      <= litw_pkg::scan_start(in_slot, in_span_down);
      now_sec_r  <= in_ts_sec;
      now_usec_r <= in_ts_usec;
    end else if (cmd.rd_issue) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {now_sec_r, now_usec_r};
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  // Written flags; an unwritten entry reads as time zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign old_time = rd_vld_r ? rd_data_r : '0;

  // Age pipeline: differences, scaling of seconds, then sum and compare.
  assign prod_nxt   = sdiff_r * litw_pkg::USEC_PER_SEC;
  assign age        = litw_pkg::AGE_W'(prod_r) + litw_pkg::AGE_W'(udiff3_r);
  assign window_ext = litw_pkg::AGE_W'(window_r);

  always_ff @(posedge clk) begin
    sdiff_r  <= $signed({1'b0, now_sec_r})
              - $signed({1'b0, old_time[litw_pkg::TIME_W-1:litw_pkg::USEC_W]});
    udiff_r  <= $signed({1'b0, now_usec_r})
              - $signed({1'b0, old_time[litw_pkg::USEC_W-1:0]});
    prod_r   <= prod_nxt;
    udiff3_r <= udiff_r;
  end

  // Stage valid flags and the hit accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (v3_r && (age <= window_ext)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Output register: holds a result until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      present_r <= hit_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_present = present_r;

  assign status.is_query  = (in_cmd == litw_pkg::CMD_QUERY);
  assign status.last_idx  = (idx_r == slot_r);
  assign status.pipe_busy = v1_r | v2_r | v3_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  // The scan never runs past the item's own slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (idx_r <= slot_r))
    else $error("scan index passed the item slot");

  // A result is loaded only after the compare pipeline has drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(v1_r || v2_r || v3_r))
    else $error("result loaded with compares in flight");

  // A new item is never taken while compares are in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(v1_r || v2_r || v3_r))
    else $error("item loaded with compares in flight");

  // Store writes and scan reads never share a cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_issue))
    else $error("store write during scan");

endmodule

`default_nettype wire

// ===== src/length_indexed_time_window_table.sv =====
// Keeps the last-seen timestamp for each packet-length slot of two directions and answers
// presence queries over a range of slots against a configurable age window. A record
// item passes through the write state before the next input transfer is taken. A query
// scans n = slot - start + 1 slots (1 to 128), one store read per cycle on the single read
// port, and then drains a four-stage compare pipeline (read register, differences,
// seconds scaling multiplier, sum and compare), and the next input transfer waits until that
// pipeline has drained and the result has moved into a free output register. A finished
// result sits in the output register while the next item is taken. window_us is written
// through the cfg_ port, which is always ready; write it only while the block is idle.
// After reset all stored times read as zero and the window is 3000000 microseconds.
`default_nettype none

module length_indexed_time_window_table (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [litw_pkg::WIN_W-1:0]          cfg_window_us,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_cmd,
  input  wire  [litw_pkg::LEN_W-1:0]          in_pkt_len,
  input  wire  [litw_pkg::SPAN_W-1:0]         in_span_down,
  input  wire                                 in_direction,
  input  wire  [litw_pkg::SEC_W-1:0]          in_ts_sec,
  input  wire  [litw_pkg::USEC_W-1:0]         in_ts_usec,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                out_present
);

  litw_pkg::ctrl_cmd_t  cmd;
  litw_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  litw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, compare pipeline and result register.
  litw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_window_us (cfg_window_us),
    .in_cmd        (in_cmd),
    .in_pkt_len    (in_pkt_len),
    .in_span_down  (in_span_down),
    .in_direction  (in_direction),
    .in_ts_sec     (in_ts_sec),
    .in_ts_usec    (in_ts_usec),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_present   (out_present),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire

// ===== dv/litw_presence_checker.sv =====
`timescale 1ns / 1ps

module litw_presence_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire [litw_pkg::WIN_W-1:0]     cfg_window_us,
  input  wire                           in_valid,
  input  wire                           in_stall,
  input  wire                           in_cmd,
  input  wire [litw_pkg::LEN_W-1:0]     in_pkt_len,
  input  wire [litw_pkg::SPAN_W-1:0]    in_span_down,
  input  wire                           in_direction,
  input  wire [litw_pkg::SEC_W-1:0]     in_ts_sec,
  input  wire [litw_pkg::USEC_W-1:0]    in_ts_usec,
  input  wire                           out_valid,
  input  wire                           out_stall,
  input  wire                           out_present,
  input  wire                           run_done,
  output int                            mismatch_count,
  output int                            results_owed
);

  // Mirror of the two timestamp stores and the window register.
  logic [litw_pkg::TIME_W-1:0] seen_dir_one [litw_pkg::TABLE_SLOTS];
  logic [litw_pkg::TIME_W-1:0] seen_dir_two [litw_pkg::TABLE_SLOTS];
  logic [litw_pkg::WIN_W-1:0]  window_now;
  bit                          presence_due [$];
  bit                          leftovers_checked;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    mismatch_count = mismatch_count + 1;
  endtask

  // Packet length to slot: floored at zero, saturated at the top slot.
  function automatic int length_slot(input logic [litw_pkg::LEN_W-1:0] len);
    if (len <= litw_pkg::MIN_LEN) begin
      return 0;
    end
    if (int'(len) - litw_pkg::MIN_LEN > litw_pkg::TABLE_SLOTS - 1) begin
      return litw_pkg::TABLE_SLOTS - 1;
    end
    return int'(len) - litw_pkg::MIN_LEN;
  endfunction

  // Signed age in microseconds; a stamp from the future also counts as fresh.
  function automatic bit fresh_enough(input logic [litw_pkg::SEC_W-1:0] sec,
                                      input logic [litw_pkg::USEC_W-1:0] usec,
                                      input logic [litw_pkg::TIME_W-1:0] stamp);
    longint age;
    age = (longint'(sec) - longint'(stamp[litw_pkg::TIME_W-1:litw_pkg::USEC_W]))
          * longint'(1000000)
          + (longint'(usec) - longint'(stamp[litw_pkg::USEC_W-1:0]));
    return age <= longint'(window_now);
  endfunction

  // Scan from the slot down by the span, never below slot zero.
  function automatic bit range_presence(input logic dir, input int slot,
                                        input logic [litw_pkg::SPAN_W-1:0] span,
                                        input logic [litw_pkg::SEC_W-1:0] sec,
                                        input logic [litw_pkg::USEC_W-1:0] usec);
    int first;
    int s;
    logic [litw_pkg::TIME_W-1:0] stamp;
    first = (int'(span) >= slot) ? 0 : slot - int'(span);
    for (s = first; s <= slot; s++) begin
      stamp = dir ? seen_dir_two[s] : seen_dir_one[s];
      if (fresh_enough(sec, usec, stamp)) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    int slot;
    bit want;
    if (!rst_n) begin
      for (int s = 0; s < litw_pkg::TABLE_SLOTS; s++) begin
        seen_dir_one[s] = '0;
        seen_dir_two[s] = '0;
      end
      window_now = litw_pkg::WINDOW_RESET;
      presence_due.delete();
      mismatch_count = 0;
      leftovers_checked = 1'b0;
    end else begin
      // Window register writes.
      if (cfg_valid && cfg_ready) begin
        window_now = cfg_window_us;
      end

      // Result transfers are matched against the oldest open query.
      if (out_valid && !out_stall) begin
        if (presence_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, present=%0b", out_present));
        end else begin
          want = presence_due.pop_front();
          if (out_present !== want) begin
            report_mismatch($sformatf("present: expected %0b, got %0b", want, out_present));
          end
        end
      end

      // Input transfers update the mirror or queue a presence answer.
      if (in_valid && !in_stall) begin
        slot = length_slot(in_pkt_len);
        if (in_cmd == litw_pkg::CMD_RECORD) begin
          if (in_direction) begin
            seen_dir_two[slot] = {in_ts_sec, in_ts_usec};
          end else begin
            seen_dir_one[slot] = {in_ts_sec, in_ts_usec};
          end
        end else begin
          presence_due.push_back(range_presence(in_direction, slot, in_span_down,
                                                in_ts_sec, in_ts_usec));
        end
      end

      // At the end of the run nothing may still be owed.
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (presence_due.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    presence_due.size()));
        end
      end
    end
    results_owed <= presence_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int RUN_LIMIT     = 500000;
  localparam int SETTLE_CYCLES = 140;
  localparam int PHASE_ITEMS   = 58;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [litw_pkg::WIN_W-1:0]     cfg_window_us = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_cmd = litw_pkg::CMD_RECORD;
  logic [litw_pkg::LEN_W-1:0]     in_pkt_len = '0;
  logic [litw_pkg::SPAN_W-1:0]    in_span_down = '0;
  logic                           in_direction = 1'b0;
  logic [litw_pkg::SEC_W-1:0]     in_ts_sec = '0;
  logic [litw_pkg::USEC_W-1:0]    in_ts_usec = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_present;
  logic                           run_done = 1'b0;
  int                             mismatch_count;
  int                             results_owed;

  // Idling is switched off for stretches of the run.
  bit                             calm = 1'b0;
  logic [litw_pkg::SEC_W-1:0]     clock_sec = '0;
  int                             stall_left = 0;
  int                             cycle_count = 0;

  length_indexed_time_window_table uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_window_us (cfg_window_us),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pkt_len    (in_pkt_len),
    .in_span_down  (in_span_down),
    .in_direction  (in_direction),
    .in_ts_sec     (in_ts_sec),
    .in_ts_usec    (in_ts_usec),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_present   (out_present)
  );

  litw_presence_checker presence_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_us  (cfg_window_us),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_pkt_len     (in_pkt_len),
    .in_span_down   (in_span_down),
    .in_direction   (in_direction),
    .in_ts_sec      (in_ts_sec),
    .in_ts_usec     (in_ts_usec),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_present    (out_present),
    .run_done       (run_done),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #6 clk = ~clk;

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("length_indexed_time_window_table: mismatch");
      $finish;
    end
  end

  // After each result transfer the receiver holds off for a random number of cycles.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = calm ? 0 : $urandom_range(0, 11);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic write_window(input logic [litw_pkg::WIN_W-1:0] value);
    cfg_window_us <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One input transfer, preceded by a random gap.
  task automatic push_item(input logic cmd, input logic [litw_pkg::LEN_W-1:0] len,
                           input logic [litw_pkg::SPAN_W-1:0] span, input logic dir,
                           input logic [litw_pkg::SEC_W-1:0] sec,
                           input logic [litw_pkg::USEC_W-1:0] usec);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= cmd;
    in_pkt_len <= len;
    in_span_down <= span;
    in_direction <= dir;
    in_ts_sec <= sec;
    in_ts_usec <= usec;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly traffic around a running clock on nearby slots, some fully random noise.
  task automatic random_item();
    logic                          cmd;
    logic [litw_pkg::LEN_W-1:0]    len;
    logic [litw_pkg::SPAN_W-1:0]   span;
    logic                          dir;
    logic [litw_pkg::SEC_W-1:0]    sec;
    logic [litw_pkg::USEC_W-1:0]   usec;
    cmd = ($urandom_range(0, 1) == 0) ? litw_pkg::CMD_RECORD : litw_pkg::CMD_QUERY;
    dir = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      clock_sec = clock_sec + litw_pkg::SEC_W'($urandom_range(0, 1));
      len = litw_pkg::LEN_W'(litw_pkg::MIN_LEN + $urandom_range(0, 24));
      span = ($urandom_range(0, 7) == 0) ? litw_pkg::SPAN_W'($urandom)
                                         : litw_pkg::SPAN_W'($urandom_range(0, 4));
      sec = clock_sec - litw_pkg::SEC_W'($urandom_range(0, 1))
            + ((cmd == litw_pkg::CMD_QUERY) ? litw_pkg::SEC_W'($urandom_range(0, 4))
                                            : litw_pkg::SEC_W'(0));
      usec = litw_pkg::USEC_W'($urandom_range(0, 999999));
    end else begin
      len = litw_pkg::LEN_W'($urandom);
      span = litw_pkg::SPAN_W'($urandom);
      sec = $urandom;
      usec = litw_pkg::USEC_W'($urandom);
    end
    push_item(cmd, len, span, dir, sec, usec);
  endtask

  // Let all open queries drain and any record finish before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [litw_pkg::WIN_W-1:0] windows [7];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_window(litw_pkg::WINDOW_RESET);

    // Directed items under the default window.
    push_item(litw_pkg::CMD_QUERY,  16'd60,   8'd0,  1'b0, 32'd0,    20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd60,   8'd0,  1'b0, 32'd5,    20'd0);
    push_item(litw_pkg::CMD_RECORD, 16'd0,    8'd0,  1'b0, 32'd100,  20'd500000);
    push_item(litw_pkg::CMD_QUERY,  16'd60,   8'd0,  1'b0, 32'd102,  20'd0);
    // Query older than the stored stamp.
    push_item(litw_pkg::CMD_QUERY,  16'd30,   8'd0,  1'b0, 32'd50,   20'd0);
    // Longest length lands in the top slot; ages just below, at and above the window.
    push_item(litw_pkg::CMD_RECORD, 16'hFFFF, 8'd0,  1'b1, 32'd1000, 20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd187,  8'd0,  1'b1, 32'd1002, 20'd999999);
    push_item(litw_pkg::CMD_QUERY,  16'd187,  8'd0,  1'b1, 32'd1003, 20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd187,  8'd0,  1'b1, 32'd1003, 20'd1);
    // Spans reaching below slot zero, exactly to it, and stopping one short.
    push_item(litw_pkg::CMD_QUERY,  16'd70,   8'hFF, 1'b0, 32'd101,  20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd70,   8'hFF, 1'b0, 32'd500,  20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd70,   8'd10, 1'b0, 32'd101,  20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd70,   8'd9,  1'b0, 32'd101,  20'd0);
    // Microsecond values beyond one second.
    push_item(litw_pkg::CMD_RECORD, 16'd100,  8'd0,  1'b0, 32'd200,  20'hFFFFF);
    push_item(litw_pkg::CMD_QUERY,  16'd100,  8'd0,  1'b0, 32'd203,  20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd100,  8'd0,  1'b0, 32'd201,  20'hFFFFF);
    // Largest stamp, then direction separation and the largest query time.
    push_item(litw_pkg::CMD_RECORD, 16'd120,  8'd0,  1'b1, 32'hFFFFFFFF, 20'd999999);
    push_item(litw_pkg::CMD_QUERY,  16'd120,  8'd0,  1'b1, 32'd0,    20'd0);
    push_item(litw_pkg::CMD_QUERY,  16'd100,  8'd0,  1'b1, 32'd100,  20'd500000);
    push_item(litw_pkg::CMD_QUERY,  16'd61,   8'd0,  1'b0, 32'hFFFFFFFF, 20'hFFFFF);

    // Random phases, each under its own window.
    windows[0] = '0;
    windows[1] = '1;
    windows[2] = litw_pkg::WIN_W'(1000000);
    windows[3] = litw_pkg::WIN_W'(1);
    windows[4] = $urandom;
    windows[5] = litw_pkg::WIN_W'($urandom_range(0, 5000000));
    windows[6] = litw_pkg::WINDOW_RESET;
    for (int p = 0; p < 7; p++) begin
      settle();
      write_window(windows[p]);
      clock_sec = ($urandom_range(0, 2) == 0) ? litw_pkg::SEC_W'($urandom_range(0, 8))
                                              : $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 20 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        random_item();
      end
    end

    settle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("length_indexed_time_window_table: match");
    end else begin
      $display("length_indexed_time_window_table: mismatch");
    end
    $finish;
  end

endmodule
